// ===== hw/rtl/trdq_pkg.sv =====
`default_nettype none

package trdq_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int LEVEL_W     = 5;

    // field widths
    localparam int STAMP_W  = 48;
    localparam int COUNT_W  = 13;
    localparam int HANDLE_W = 16;
    localparam int SCORE_W  = 16;
    localparam int INC_W    = 10;

    localparam logic [STAMP_W-1:0] STAMP_MAX     = {STAMP_W{1'b1}};
    localparam logic [COUNT_W:0]   COUNT_MODULUS = 14'd5000;

    // opcodes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status codes
    localparam logic [3:0] ST_INSERTED  = 4'd0;
    localparam logic [3:0] ST_DUP       = 4'd1;
    localparam logic [3:0] ST_CONFLICT  = 4'd2;
    localparam logic [3:0] ST_LATE      = 4'd3;
    localparam logic [3:0] ST_DUP_LATE  = 4'd4;
    localparam logic [3:0] ST_INHIBITED = 4'd5;
    localparam logic [3:0] ST_EMPTY     = 4'd6;
    localparam logic [3:0] ST_RELEASED  = 4'd7;
    localparam logic [3:0] ST_BREAK     = 4'd8;

    // configuration register indexes
    localparam logic [2:0] CFG_DELAY_ENABLE  = 3'd0;
    localparam logic [2:0] CFG_RELEASE_DELAY = 3'd1;
    localparam logic [2:0] CFG_LATE_INC      = 3'd2;
    localparam logic [2:0] CFG_LATE_CEILING  = 3'd3;
    localparam logic [2:0] CFG_LATE_LIMIT    = 3'd4;
    localparam logic [2:0] CFG_BACKOFF       = 3'd5;

    // cell update modes
    localparam logic [1:0] CELL_HOLD        = 2'd0;
    localparam logic [1:0] CELL_INSERT      = 2'd1;
    localparam logic [1:0] CELL_INSERT_FULL = 2'd2;
    localparam logic [1:0] CELL_SHIFT       = 2'd3;

    typedef struct packed {
        logic [STAMP_W-1:0]  stamp;
        logic [COUNT_W-1:0]  count;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic [1:0] mode;
        entry_t     item;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/trdq_cell.sv =====
`default_nettype none

module trdq_cell (
    input  wire                 clk,
    input  trdq_pkg::cell_cmd_t cmd,
    input  wire                 occupied,
    input  wire                 left_ins,
    input  trdq_pkg::entry_t    left_entry,
    input  trdq_pkg::entry_t    right_post,
    input  trdq_pkg::entry_t    right_entry,
    output trdq_pkg::entry_t    entry,
    output trdq_pkg::entry_t    post,
    output logic                ins,
    output logic                match,
    output logic                same_count
);
    import trdq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // new item belongs at or before this slot
    assign ins        = !occupied || (cmd.item.stamp < entry_reg.stamp);
    assign match      = occupied && (cmd.item.stamp == entry_reg.stamp);
    assign same_count = match && (cmd.item.count == entry_reg.count);

    // slot content after an insert, before any overflow shift
    always_comb
    begin
        if (!ins)
        begin
            post = entry_reg;
        end
        else if (left_ins)
        begin
            post = left_entry;
        end
        else
        begin
            post = cmd.item;
        end
    end

    // next slot content
    always_comb
    begin
        case (cmd.mode)
            CELL_HOLD:        entry_next = entry_reg;
            CELL_INSERT:      entry_next = post;
            CELL_INSERT_FULL: entry_next = right_post;
            CELL_SHIFT:       entry_next = right_entry;
            default:          entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/timestamp_reorder_dedup_queue_top.sv =====
`default_nettype none
// a result appears on the master side in the cycle after its input transfer
// throughput: one transfer per cycle; the whole cell row updates together,
// and the input is stalled only while a finished result waits on the output
// reset: rst_n clears queue level, late score, release and continuity tracking,
// inhibit time and the configuration registers to their defaults; entries are not cleared

module timestamp_reorder_dedup_queue_top (
    input  wire         clk,
    input  wire         rst_n,
    // configuration write port
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [15:0] cfg_data,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    // frame_stamp[47:0], stamp_present[48], frame_count[61:49],
    // payload_handle[77:62], now_ms[125:78], zero fill
    input  wire  [127:0] s_tdata,
    // opcode[0]
    input  wire  [0:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    // overrun_drop[0], out_stamp[48:1], out_count[61:49], out_handle[77:62],
    // send_ok[78], queue_level[83:79], late_level[99:84], running_ok[100], zero fill
    output logic [103:0] m_tdata,
    // status[3:0]
    output logic [3:0]  m_tuser
);
    import trdq_pkg::*;

    // configuration registers
    logic                delay_enable_reg;
    logic [15:0]         release_delay_reg;
    logic [INC_W-1:0]    late_inc_reg;
    logic [SCORE_W-1:0]  late_ceiling_reg;
    logic [SCORE_W-1:0]  late_limit_reg;
    logic [15:0]         backoff_reg;

    // control state
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [STAMP_W-1:0]  last_stamp_reg, last_stamp_next;
    logic                last_valid_reg, last_valid_next;
    logic [SCORE_W-1:0]  score_reg, score_next;
    logic [STAMP_W-1:0]  inhibit_reg, inhibit_next;
    logic [COUNT_W-1:0]  prior_reg, prior_next;
    logic                prior_valid_reg, prior_valid_next;

    // output register
    logic                out_valid_reg;
    logic [3:0]          out_status_reg;
    logic                out_drop_reg;
    entry_t              out_entry_reg;
    logic                out_send_reg;
    logic [LEVEL_W-1:0]  out_level_reg;
    logic [SCORE_W-1:0]  out_score_reg;
    logic                out_running_reg;

    // input fields
    logic                in_opcode;
    logic [STAMP_W-1:0]  in_stamp;
    logic                in_present;
    logic [COUNT_W-1:0]  in_count;
    logic [HANDLE_W-1:0] in_handle;
    logic [STAMP_W-1:0]  in_now;
    logic                s_fire;

    // cell row
    cell_cmd_t           cmd;
    logic [1:0]          cmd_mode;
    entry_t              cell_entry [QUEUE_DEPTH+1];
    entry_t              cell_post  [QUEUE_DEPTH+1];
    entry_t              left_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]   ins_chain;
    logic [QUEUE_DEPTH-1:0] occ;
    logic [QUEUE_DEPTH-1:0] match_vec;
    logic [QUEUE_DEPTH-1:0] same_vec;

    // step results
    logic [3:0]          status;
    logic                drop;
    entry_t              o_entry;
    logic                send_ok;

    logic                is_late;
    logic                before_release;
    logic                inhibited;
    logic                full;
    logic [SCORE_W:0]    late_sum;
    logic [SCORE_W-1:0]  late_capped;
    logic [COUNT_W:0]    prior_inc;
    logic [COUNT_W:0]    prior_wrap;
    logic                count_break;
    logic [STAMP_W:0]    inhibit_sum;
    logic [STAMP_W-1:0]  inhibit_sat;

    assign in_opcode  = s_tuser[0];
    assign in_stamp   = s_tdata[47:0];
    assign in_present = s_tdata[48];
    assign in_count   = s_tdata[61:49];
    assign in_handle  = s_tdata[77:62];
    assign in_now     = s_tdata[125:78];

    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_enable_reg  <= 1'b1;
            release_delay_reg <= 16'd500;
            late_inc_reg      <= 10'd10;
            late_ceiling_reg  <= 16'd100;
            late_limit_reg    <= 16'd50;
            backoff_reg       <= 16'd5000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DELAY_ENABLE:  delay_enable_reg  <= cfg_data[0];
                CFG_RELEASE_DELAY: release_delay_reg <= cfg_data;
                CFG_LATE_INC:      late_inc_reg      <= cfg_data[INC_W-1:0];
                CFG_LATE_CEILING:  late_ceiling_reg  <= cfg_data;
                CFG_LATE_LIMIT:    late_limit_reg    <= cfg_data;
                CFG_BACKOFF:       backoff_reg       <= cfg_data;
                default:           ;
            endcase
        end
    end

    // row of sorted cells
    assign cmd          = {cmd_mode, in_stamp, in_count, in_handle};
    assign ins_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            assign occ[gi] = FILL_W'(gi) < fill_reg;

            if (gi == 0)
            begin : g_first
                assign left_entry[gi] = cmd.item;
            end
            else
            begin : g_rest
                assign left_entry[gi] = cell_entry[gi-1];
            end

            trdq_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (occ[gi]),
                .left_ins    (ins_chain[gi]),
                .left_entry  (left_entry[gi]),
                .right_post  (cell_post[gi+1]),
                .right_entry (cell_entry[gi+1]),
                .entry       (cell_entry[gi]),
                .post        (cell_post[gi]),
                .ins         (ins_chain[gi+1]),
                .match       (match_vec[gi]),
                .same_count  (same_vec[gi])
            );
        end
    endgenerate

    // virtual slot past the end of the row
    assign cell_entry[QUEUE_DEPTH] = cell_entry[QUEUE_DEPTH-1];
    assign cell_post[QUEUE_DEPTH]  = ins_chain[QUEUE_DEPTH] ? cell_entry[QUEUE_DEPTH-1]
                                                            : cmd.item;

    // push checks
    assign is_late = delay_enable_reg &&
                     (!in_present ||
                      (({1'b0, in_stamp} + (STAMP_W+1)'(release_delay_reg)) < {1'b0, in_now}));
    assign before_release = last_valid_reg && (last_stamp_reg >= in_stamp);
    assign inhibited      = in_now < inhibit_reg;
    assign full           = fill_reg == FILL_W'(QUEUE_DEPTH);

    // saturating late score
    assign late_sum    = {1'b0, score_reg} + (SCORE_W+1)'(late_inc_reg);
    assign late_capped = (late_sum > {1'b0, late_ceiling_reg}) ? late_ceiling_reg
                                                               : late_sum[SCORE_W-1:0];

    // counter continuity modulo 5000
    assign prior_inc   = {1'b0, prior_reg} + (COUNT_W+1)'(1);
    assign prior_wrap  = (prior_inc >= COUNT_MODULUS) ? (prior_inc - COUNT_MODULUS) : prior_inc;
    assign count_break = prior_valid_reg && (prior_wrap != {1'b0, cell_entry[0].count});

    // backoff end, saturated
    assign inhibit_sum = {1'b0, in_now} + (STAMP_W+1)'(backoff_reg);
    assign inhibit_sat = inhibit_sum[STAMP_W] ? STAMP_MAX : inhibit_sum[STAMP_W-1:0];

    // step control
    always_comb
    begin
        fill_next        = fill_reg;
        last_stamp_next  = last_stamp_reg;
        last_valid_next  = last_valid_reg;
        score_next       = score_reg;
        inhibit_next     = inhibit_reg;
        prior_next       = prior_reg;
        prior_valid_next = prior_valid_reg;
        cmd_mode         = CELL_HOLD;
        status           = ST_INSERTED;
        drop             = 1'b0;
        o_entry          = '0;
        send_ok          = 1'b0;

        if (s_fire)
        begin
            if (in_opcode == OP_PUSH)
            begin
                if (before_release)
                begin
                    status = ST_DUP_LATE;
                end
                else if (is_late)
                begin
                    score_next = late_capped;
                    status     = ST_LATE;
                end
                else if (inhibited)
                begin
                    status = ST_INHIBITED;
                end
                else
                begin
                    if (|match_vec)
                    begin
                        status = (|same_vec) ? ST_DUP : ST_CONFLICT;
                    end
                    else if (full)
                    begin
                        cmd_mode = CELL_INSERT_FULL;
                        drop     = 1'b1;
                    end
                    else
                    begin
                        cmd_mode  = CELL_INSERT;
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    if (score_reg != '0)
                    begin
                        score_next = score_reg - SCORE_W'(1);
                    end
                end
            end
            else if (fill_reg == '0)
            begin
                status = ST_EMPTY;
            end
            else
            begin
                o_entry         = cell_entry[0];
                cmd_mode        = CELL_SHIFT;
                fill_next       = fill_reg - FILL_W'(1);
                last_stamp_next = cell_entry[0].stamp;
                last_valid_next = 1'b1;
                prior_next      = cell_entry[0].count;
                if (count_break)
                begin
                    inhibit_next     = inhibit_sat;
                    fill_next        = '0;
                    score_next       = '0;
                    prior_valid_next = 1'b0;
                    status           = ST_BREAK;
                end
                else
                begin
                    prior_valid_next = 1'b1;
                    status           = ST_RELEASED;
                end
                send_ok = !(in_now < inhibit_next);
            end
        end
    end

    // control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= '0;
            last_stamp_reg  <= '0;
            last_valid_reg  <= 1'b0;
            score_reg       <= '0;
            inhibit_reg     <= '0;
            prior_reg       <= '0;
            prior_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg        <= fill_next;
            last_stamp_reg  <= last_stamp_next;
            last_valid_reg  <= last_valid_next;
            score_reg       <= score_next;
            inhibit_reg     <= inhibit_next;
            prior_reg       <= prior_next;
            prior_valid_reg <= prior_valid_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload, captured on each input transfer
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            out_status_reg  <= status;
            out_drop_reg    <= drop;
            out_entry_reg   <= o_entry;
            out_send_reg    <= send_ok;
            out_level_reg   <= LEVEL_W'(fill_next);
            out_score_reg   <= score_next;
            out_running_reg <= score_next < late_limit_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000, out_running_reg, out_score_reg, out_level_reg, out_send_reg,
                       out_entry_reg.handle, out_entry_reg.count, out_entry_reg.stamp,
                       out_drop_reg};

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("queue level above depth");

    a_pop_level: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && in_opcode == OP_POP && fill_reg != '0) |=>
        (fill_reg == $past(fill_reg) - FILL_W'(1) || fill_reg == '0))
        else $error("release did not lower the queue level");

    a_send_release: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_send_reg) |->
        (out_status_reg == ST_RELEASED || out_status_reg == ST_BREAK))
        else $error("send flag on a result without a release");

    generate
        for (gi = 0; gi < QUEUE_DEPTH - 1; gi++)
        begin : g_order_chk
            a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                occ[gi+1] |-> (cell_entry[gi].stamp < cell_entry[gi+1].stamp))
                else $error("queue entries out of timestamp order");
        end
    endgenerate

endmodule

`default_nettype wire
